FILE: rtl/b32enc_pkg.sv
// shared types, constants and functions of the bech32 address encoder
`default_nettype none

package b32enc_pkg;

	localparam int ADDR_BYTES_DEF = 20;
	localparam int MAX_PREFIX_DEF = 5;

	localparam int CHK_W     = 30;
	localparam int ACC_W     = 12;
	localparam int CNT_W     = 4;
	localparam int STEP_W    = 3;
	localparam int CHAR_W    = 7;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 40;
	localparam int PLEN_W    = 3;
	localparam int CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_CHARS  = 1'd1;

	localparam logic [PLEN_W-1:0] PLEN_RESET  = 3'd2;
	localparam logic [CFG_W-1:0]  PCHAR_RESET = 40'd25442;

	localparam logic [CHAR_W-1:0] SEP_CHAR = 7'h31;
	localparam logic [STEP_W-1:0] CHK_LAST_STEP = 3'd5;

	localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	localparam logic [CHK_W-1:0] GEN0 = 30'h3b6a57b2;
	localparam logic [CHK_W-1:0] GEN1 = 30'h26508e6d;
	localparam logic [CHK_W-1:0] GEN2 = 30'h1ea119fa;
	localparam logic [CHK_W-1:0] GEN3 = 30'h3d4233dd;
	localparam logic [CHK_W-1:0] GEN4 = 30'h2a1462b3;

	// datapath operations issued by the controller
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
	localparam logic [OP_W-1:0] OP_PFX_EMIT = 4'd2;
	localparam logic [OP_W-1:0] OP_SEP_EMIT = 4'd3;
	localparam logic [OP_W-1:0] OP_FOLD_HI  = 4'd4;
	localparam logic [OP_W-1:0] OP_FOLD_Z   = 4'd5;
	localparam logic [OP_W-1:0] OP_FOLD_LO  = 4'd6;
	localparam logic [OP_W-1:0] OP_GROUP    = 4'd7;
	localparam logic [OP_W-1:0] OP_PAD      = 4'd8;
	localparam logic [OP_W-1:0] OP_NEXT     = 4'd9;
	localparam logic [OP_W-1:0] OP_XOR      = 4'd10;
	localparam logic [OP_W-1:0] OP_CHK_EMIT = 4'd11;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic              first;
		logic              last;
		logic [PLEN_W-1:0] len;
		logic              grp_rdy;
		logic              pad_need;
		logic              out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] alpha_char(input logic [4:0] g);
		logic [7:0] c;
		c = ALPHABET[8*(31-int'(g)) +: 8];
		return c[CHAR_W-1:0];
	endfunction

	// one step of the bch polymod
	function automatic logic [CHK_W-1:0] fold(input logic [CHK_W-1:0] chk,
		input logic [4:0] v);
		logic [4:0]       top;
		logic [CHK_W-1:0] r;
		top = chk[29:25];
		r = {chk[24:0], v};
		if (top[0]) r = r ^ GEN0;
		if (top[1]) r = r ^ GEN1;
		if (top[2]) r = r ^ GEN2;
		if (top[3]) r = r ^ GEN3;
		if (top[4]) r = r ^ GEN4;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/b32enc_dp.sv
// datapath: config registers, regrouping, checksum register and output word register
`default_nettype none

module b32enc_dp #(
	parameter int ADDR_BYTES = b32enc_pkg::ADDR_BYTES_DEF,
	parameter int MAX_PREFIX = b32enc_pkg::MAX_PREFIX_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [b32enc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire  [b32enc_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire  [b32enc_pkg::BYTE_W-1:0]         in_byte,
	input  wire  b32enc_pkg::cmd_t                cmd,
	output b32enc_pkg::sts_t                      sts,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [b32enc_pkg::CHAR_W-1:0]         out_char,
	output logic                                  out_last
);
	import b32enc_pkg::*;

	localparam int IDX_W = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
	localparam int PC_W  = 8 * MAX_PREFIX;

	logic [PLEN_W-1:0] plen_cfg_q;
	logic [CFG_W-1:0]  pchar_cfg_q;
	logic [PLEN_W-1:0] len_q;
	logic [PC_W-1:0]   chars_q;
	logic [CHK_W-1:0]  chk_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;

	logic [PLEN_W-1:0] len_clamp;
	logic [7:0]        pchar;
	logic [CNT_W-1:0]  cnt_sub;
	logic [4:0]        grp;
	logic [9:0]        pad_ext;
	logic [4:0]        pad_grp;
	logic [4:0]        chk_grp;
	logic [4:0]        fold_v;
	logic              do_fold;
	logic              emit;
	logic [CHAR_W-1:0] emit_char;
	logic              chk_done;

	always_comb begin
		if (plen_cfg_q == '0) begin
			len_clamp = PLEN_W'(1);
		end else if (plen_cfg_q > PLEN_W'(MAX_PREFIX)) begin
			len_clamp = PLEN_W'(MAX_PREFIX);
		end else begin
			len_clamp = plen_cfg_q;
		end
	end

	assign pchar   = chars_q[8*int'(cmd.step) +: 8];
	assign cnt_sub = cnt_q - CNT_W'(5);
	assign grp     = 5'(acc_q >> cnt_sub);
	// leftover bits moved to the top of the last group
	assign pad_ext = {acc_q[4:0], 5'd0} >> cnt_q;
	assign pad_grp = pad_ext[4:0];
	assign chk_grp = 5'(chk_q >> (5 * (5 - int'(cmd.step))));
	assign chk_done = (cmd.op == OP_CHK_EMIT) && (cmd.step == CHK_LAST_STEP);

	always_comb begin
		fold_v    = '0;
		do_fold   = 1'b0;
		emit      = 1'b0;
		emit_char = '0;
		case (cmd.op)
			OP_PFX_EMIT: begin
				emit      = 1'b1;
				emit_char = pchar[CHAR_W-1:0];
			end
			OP_SEP_EMIT: begin
				emit      = 1'b1;
				emit_char = SEP_CHAR;
			end
			OP_FOLD_HI: begin
				do_fold = 1'b1;
				fold_v  = {2'b00, pchar[7:5]};
			end
			OP_FOLD_Z: begin
				do_fold = 1'b1;
			end
			OP_FOLD_LO: begin
				do_fold = 1'b1;
				fold_v  = pchar[4:0];
			end
			OP_GROUP: begin
				do_fold   = 1'b1;
				fold_v    = grp;
				emit      = 1'b1;
				emit_char = alpha_char(grp);
			end
			OP_PAD: begin
				do_fold   = 1'b1;
				fold_v    = pad_grp;
				emit      = 1'b1;
				emit_char = alpha_char(pad_grp);
			end
			OP_CHK_EMIT: begin
				emit      = 1'b1;
				emit_char = alpha_char(chk_grp);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_cfg_q  <= PLEN_RESET;
			pchar_cfg_q <= PCHAR_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_PREFIX_LENGTH) begin
				plen_cfg_q <= cfg_wdata[PLEN_W-1:0];
			end
			if (cfg_idx == REG_PREFIX_CHARS) begin
				pchar_cfg_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= CHK_W'(1);
			acc_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			len_q <= PLEN_W'(1);
		end else begin
			if (cmd.op == OP_ACCEPT) begin
				acc_q <= {acc_q[3:0], in_byte};
				cnt_q <= cnt_q + CNT_W'(8);
				if (idx_q == '0) begin
					chk_q <= CHK_W'(1);
					len_q <= len_clamp;
				end
			end
			if (do_fold) begin
				chk_q <= fold(chk_q, fold_v);
			end
			if (cmd.op == OP_GROUP) begin
				cnt_q <= cnt_sub;
			end
			if (cmd.op == OP_PAD) begin
				cnt_q <= '0;
			end
			if (cmd.op == OP_XOR) begin
				chk_q <= chk_q ^ CHK_W'(1);
			end
			if (cmd.op == OP_NEXT) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (chk_done) begin
				chk_q <= CHK_W'(1);
				acc_q <= '0;
				cnt_q <= '0;
				idx_q <= '0;
			end
		end
	end

	// prefix characters are held for the whole address
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && idx_q == '0) begin
			chars_q <= pchar_cfg_q[PC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char <= emit_char;
			out_last <= chk_done;
		end
	end

	always_comb begin
		sts.first    = (idx_q == '0);
		sts.last     = (idx_q == IDX_W'(ADDR_BYTES - 1));
		sts.len      = len_q;
		sts.grp_rdy  = (cnt_q >= CNT_W'(5));
		sts.pad_need = (cnt_q != '0);
		sts.out_free = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

FILE: rtl/b32enc_ctrl.sv
// controller: sequences prefix, groups, padding and checksum for each address word
`default_nettype none

module b32enc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  b32enc_pkg::sts_t sts,
	output b32enc_pkg::cmd_t      cmd
);
	import b32enc_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_PFX  = 4'd1;
	localparam logic [ST_W-1:0] ST_SEP  = 4'd2;
	localparam logic [ST_W-1:0] ST_HI   = 4'd3;
	localparam logic [ST_W-1:0] ST_ZERO = 4'd4;
	localparam logic [ST_W-1:0] ST_LO   = 4'd5;
	localparam logic [ST_W-1:0] ST_GRP  = 4'd6;
	localparam logic [ST_W-1:0] ST_PAD  = 4'd7;
	localparam logic [ST_W-1:0] ST_ZF   = 4'd8;
	localparam logic [ST_W-1:0] ST_XOR  = 4'd9;
	localparam logic [ST_W-1:0] ST_CHK  = 4'd10;

	logic [ST_W-1:0]   state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              pfx_end;

	assign in_ready = (state_q == ST_IDLE);
	assign pfx_end  = (step_q == sts.len - PLEN_W'(1));

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					step_d  = '0;
					state_d = sts.first ? ST_PFX : ST_GRP;
				end
			end
			ST_PFX: begin
				if (sts.out_free) begin
					cmd.op = OP_PFX_EMIT;
					if (pfx_end) begin
						step_d  = '0;
						state_d = ST_SEP;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			ST_SEP: begin
				if (sts.out_free) begin
					cmd.op  = OP_SEP_EMIT;
					state_d = ST_HI;
				end
			end
			ST_HI: begin
				cmd.op = OP_FOLD_HI;
				if (pfx_end) begin
					step_d  = '0;
					state_d = ST_ZERO;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_ZERO: begin
				cmd.op  = OP_FOLD_Z;
				state_d = ST_LO;
			end
			ST_LO: begin
				cmd.op = OP_FOLD_LO;
				if (pfx_end) begin
					step_d  = '0;
					state_d = ST_GRP;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_GRP: begin
				if (sts.grp_rdy) begin
					if (sts.out_free) begin
						cmd.op = OP_GROUP;
					end
				end else if (sts.last) begin
					state_d = ST_PAD;
				end else begin
					cmd.op  = OP_NEXT;
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				step_d = '0;
				if (sts.pad_need) begin
					if (sts.out_free) begin
						cmd.op  = OP_PAD;
						state_d = ST_ZF;
					end
				end else begin
					state_d = ST_ZF;
				end
			end
			ST_ZF: begin
				// six zero groups close the checksum
				cmd.op = OP_FOLD_Z;
				if (step_q == CHK_LAST_STEP) begin
					step_d  = '0;
					state_d = ST_XOR;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_XOR: begin
				cmd.op  = OP_XOR;
				step_d  = '0;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.out_free) begin
					cmd.op = OP_CHK_EMIT;
					if (step_q == CHK_LAST_STEP) begin
						step_d  = '0;
						state_d = ST_IDLE;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bech32_address_encoder_unit.sv
// top level of the bech32 address encoder: controller plus datapath
// one address byte per input word, one text character per output word
// per byte: accept, then emit each 5-bit group (1 or 2), then close
// first byte also emits prefix and separator and folds the prefix expansion
// last byte adds a pad group if bits are left, six zero groups, the xor and six checksum characters
// reset clears the checksum and regrouping state; prefix resets to length 2, "bc"
`default_nettype none

module bech32_address_encoder_unit #(
	parameter int ADDR_BYTES = b32enc_pkg::ADDR_BYTES_DEF,
	parameter int MAX_PREFIX = b32enc_pkg::MAX_PREFIX_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,   // [7:0] addr_byte
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [7:0]                        m_tdata,   // [6:0] out_char, [7] zero
	output logic                              m_tlast,   // is_last
	input  wire                               cfg_we,
	input  wire  [b32enc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire  [b32enc_pkg::CFG_W-1:0]      cfg_wdata
);
	import b32enc_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [CHAR_W-1:0] out_char;

	b32enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	b32enc_dp #(
		.ADDR_BYTES (ADDR_BYTES),
		.MAX_PREFIX (MAX_PREFIX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

FILE: test/bech32_address_encoder_unit_tb.sv
// self-checking testbench of the bech32 address encoder, with its own text predictor
`default_nettype none

module bech32_address_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_LEN     = b32enc_pkg::ADDR_BYTES_DEF;
	localparam int RAND_ADDRS   = 13;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 40;

	typedef struct packed {
		logic       last;
		logic [6:0] ch;
	} text_char_t;

	class bech32_scoreboard;
		bit [2:0]    plen;
		bit [39:0]   pchars;
		bit [29:0]   chk;
		bit [11:0]   acc;
		int unsigned nbits;
		int unsigned idx;
		text_char_t  text_q[$];
		int          mism;
		string       alpha;

		function new();
			alpha = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
			plen = 3'd2;
			pchars = 40'd25442;
			chk = 30'd1;
			acc = '0;
			nbits = 0;
			idx = 0;
			mism = 0;
		endfunction

		function void set_reg(logic [b32enc_pkg::CFG_IDX_W-1:0] ri, logic [39:0] v);
			if (ri == b32enc_pkg::REG_PREFIX_LENGTH)
				plen = v[2:0];
			else if (ri == b32enc_pkg::REG_PREFIX_CHARS)
				pchars = v;
		endfunction

		function bit [29:0] bch_fold(bit [29:0] c, bit [4:0] v);
			bit [4:0]  top;
			bit [29:0] r;
			top = c[29:25];
			r = {c[24:0], v};
			if (top[0]) r ^= 30'h3b6a57b2;
			if (top[1]) r ^= 30'h26508e6d;
			if (top[2]) r ^= 30'h1ea119fa;
			if (top[3]) r ^= 30'h3d4233dd;
			if (top[4]) r ^= 30'h2a1462b3;
			return r;
		endfunction

		function void push_char(bit [6:0] ch, bit last);
			text_char_t e;
			e.ch = ch;
			e.last = last;
			text_q.push_back(e);
		endfunction

		function void push_group(bit [4:0] g, bit last);
			byte c;
			c = alpha[g];
			push_char(c[6:0], last);
		endfunction

		// work out the characters caused by one accepted address byte
		function void note_byte(bit [7:0] b);
			int unsigned n;
			int unsigned i;
			bit [7:0]    pc;
			bit [4:0]    g;
			bit [29:0]   mod;
			if (idx == 0) begin
				n = 32'(plen);
				if (n < 1) n = 1;
				if (n > 5) n = 5;
				chk = 30'd1;
				for (i = 0; i < n; i++) begin
					pc = pchars[8*i +: 8];
					push_char(pc[6:0], 1'b0);
				end
				push_char(7'h31, 1'b0);   // separator '1'
				for (i = 0; i < n; i++) begin
					pc = pchars[8*i +: 8];
					chk = bch_fold(chk, {2'b00, pc[7:5]});
				end
				chk = bch_fold(chk, 5'd0);
				for (i = 0; i < n; i++) begin
					pc = pchars[8*i +: 8];
					chk = bch_fold(chk, pc[4:0]);
				end
			end
			acc = {acc[3:0], b};
			nbits += 8;
			while (nbits >= 5) begin
				nbits -= 5;
				g = 5'(acc >> nbits);
				chk = bch_fold(chk, g);
				push_group(g, 1'b0);
			end
			if (idx + 1 >= ADDR_LEN) begin
				if (nbits != 0) begin
					g = 5'(acc << (5 - nbits));
					chk = bch_fold(chk, g);
					push_group(g, 1'b0);
				end
				repeat (6) chk = bch_fold(chk, 5'd0);
				mod = chk ^ 30'd1;
				for (i = 0; i < 6; i++)
					push_group(mod[5*(5-i) +: 5], i == 5);
				chk = 30'd1;
				acc = '0;
				nbits = 0;
				idx = 0;
			end else begin
				idx++;
			end
		endfunction

		function void report(string what, logic [7:0] d, logic l, text_char_t e);
			mism++;
			if (mism <= 10)
				$display("mismatch (%s): got char %h last %b, expected char %h last %b",
					what, d, l, {1'b0, e.ch}, e.last);
		endfunction

		function void check_char(logic [7:0] d, logic l);
			text_char_t e;
			if (text_q.size() == 0) begin
				e = '0;
				report("no word expected", d, l, e);
				return;
			end
			e = text_q.pop_front();
			if (d !== {1'b0, e.ch} || l !== e.last)
				report("wrong word", d, l, e);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [7:0]  s_tdata = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [7:0]  m_tdata;
	wire         m_tlast;
	logic        cfg_we = 1'b0;
	logic [b32enc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [b32enc_pkg::CFG_W-1:0]     cfg_wdata = '0;

	bech32_scoreboard sb;
	bit          calm = 1'b0;
	int          quiet = 0;
	int          stall_left = 0;

	bit [7:0] corner_bytes [20] = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'h55,
		8'haa, 8'h00, 8'h00, 8'hff, 8'hff, 8'h0f, 8'hf0, 8'h10, 8'h08, 8'h84, 8'h21,
		8'hff, 8'h00};

	bech32_address_encoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output side: check every accepted word, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_char(m_tdata, m_tlast);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	// cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("** bech32_address_encoder_unit: FAILED **");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.text_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input bit do_len, input logic [2:0] len_v,
		input bit do_chars, input logic [39:0] chars_v);
		logic [39:0] wd;
		if (do_len) begin
			wd = 40'({$urandom(), $urandom()});
			wd[2:0] = len_v;
			cfg_we <= 1'b1;
			cfg_idx <= b32enc_pkg::REG_PREFIX_LENGTH;
			cfg_wdata <= wd;
			sb.set_reg(b32enc_pkg::REG_PREFIX_LENGTH, wd);
			@(posedge clk);
		end
		if (do_chars) begin
			cfg_we <= 1'b1;
			cfg_idx <= b32enc_pkg::REG_PREFIX_CHARS;
			cfg_wdata <= chars_v;
			sb.set_reg(b32enc_pkg::REG_PREFIX_CHARS, chars_v);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [39:0] pick_chars();
		logic [39:0] v;
		int k;
		if ($urandom_range(0, 1) == 0) begin
			v = 40'({$urandom(), $urandom()});
		end else begin
			// lower-case letters and digits, as a real prefix would hold
			for (k = 0; k < 5; k++)
				v[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9))
					: 8'(8'h61 + $urandom_range(0, 25));
		end
		return v;
	endfunction

	initial begin
		int a;
		int j;
		int r;
		logic [7:0] b;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset prefix, corner bytes
		for (j = 0; j < ADDR_LEN; j++)
			send_byte(corner_bytes[j]);
		wait_drained();

		for (a = 0; a < RAND_ADDRS; a++) begin
			case (a)
				0: write_regs(1'b1, 3'd0, 1'b1, 40'h0);
				1: write_regs(1'b1, 3'd7, 1'b1, 40'hff_ffff_ffff);
				2: write_regs(1'b1, 3'd1, 1'b1, pick_chars());
				3: write_regs(1'b1, 3'd5, 1'b1, 40'h7f_8000_ff01);
				4: write_regs(1'b1, 3'd6, 1'b1, pick_chars());
				default: write_regs(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), pick_chars());
			endcase
			calm = ($urandom_range(0, 3) == 0);
			for (j = 0; j < ADDR_LEN; j++) begin
				r = $urandom_range(0, 9);
				b = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
				send_byte(b);
			end
			wait_drained();
			calm = 1'b0;
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		if (sb.mism == 0 && sb.text_q.size() == 0)
			$display("** bech32_address_encoder_unit: PASSED **");
		else
			$display("** bech32_address_encoder_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
